>>> sv/aspv_pkg.sv
// Package for the AS path relation validator.
// Holds the shared codes, the pair record and the scan result type.
// Depends on nothing; used by aspv_cfg_if, all modules and the checker.
package aspv_pkg;

  // Request operations
  localparam logic OP_ADD_PAIR = 1'b0;
  localparam logic OP_SEGMENT  = 1'b1;

  // Segment types
  localparam logic [7:0] SEG_SET          = 8'd1;
  localparam logic [7:0] SEG_SEQUENCE     = 8'd2;
  localparam logic [7:0] SEG_CONFED_SEQ   = 8'd3;
  localparam logic [7:0] SEG_CONFED_SET   = 8'd4;

  // Session relation register codes
  localparam logic [1:0] SESS_CUSTOMER = 2'd0;
  localparam logic [1:0] SESS_PROVIDER = 2'd1;
  localparam logic [1:0] SESS_OTHER    = 2'd2;

  // Pair lookup outcomes
  localparam logic [1:0] LOOK_INVALID = 2'd0;
  localparam logic [1:0] LOOK_VALID   = 2'd1;
  localparam logic [1:0] LOOK_UNKNOWN = 2'd2;

  // Valley check phases
  localparam logic [1:0] PH_VALID1 = 2'd0;
  localparam logic [1:0] PH_UNK1   = 2'd1;
  localparam logic [1:0] PH_VALID2 = 2'd2;
  localparam logic [1:0] PH_UNK2   = 2'd3;

  // Verdict codes
  localparam logic [1:0] V_VALID   = 2'd0;
  localparam logic [1:0] V_INVALID = 2'd1;
  localparam logic [1:0] V_UNKNOWN = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_AS         = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_RELATION = 8'd1;

  typedef struct packed {
    logic [31:0] customer;
    logic [31:0] provider;
  } pair_t;

  typedef struct packed {
    logic done;
    logic found;
    logic seen;
  } scan_res_t;

endpackage

>>> sv/aspv_req_if.sv
// Request channel of the AS path relation validator.
// Carries one add-pair or one path-segment request; no package dependency.
interface aspv_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] customer_as;
  logic [31:0] upstream_as;
  logic [7:0]  segment_type;
  logic [7:0]  segment_length;
  logic [31:0] segment_last_as;
  logic        last_segment;

  modport source (output valid, operation, customer_as, upstream_as, segment_type,
                  segment_length, segment_last_as, last_segment, input ready);
  modport sink   (input valid, operation, customer_as, upstream_as, segment_type,
                  segment_length, segment_last_as, last_segment, output ready);
endinterface

>>> sv/aspv_rsp_if.sv
// Result channel of the AS path relation validator.
// Carries one path verdict; no package dependency.
interface aspv_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

>>> sv/aspv_cfg_if.sv
// Configuration write channel of the AS path relation validator.
// Carries a register index and write data; width taken from aspv_pkg.
interface aspv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aspv_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/aspv_pair_scan.sv
// Relation pair table and its linear search engine.
// Holds the pair memory (one read port, one write port); uses aspv_pkg.
module aspv_pair_scan #(
  parameter int Entries = 64,
  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1,
  localparam int CntW = $clog2(Entries + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [IdxW-1:0]     wr_addr,
  input  aspv_pkg::pair_t     wr_pair,
  input  logic                start,
  input  aspv_pkg::pair_t     key,
  input  logic [CntW-1:0]     count,
  output aspv_pkg::scan_res_t res
);

  aspv_pkg::pair_t mem [Entries];
  aspv_pkg::pair_t rd_data;
  aspv_pkg::pair_t key_r;
  logic            busy;
  logic            rd_valid;
  logic [CntW-1:0] idx;
  logic            seen;

  logic cust_hit;
  logic hit;
  logic fin;
  logic issue;

  // Compare the entry read last cycle and decide whether to go on
  always_comb begin
    cust_hit = rd_valid && (rd_data.customer == key_r.customer);
    hit      = cust_hit && (rd_data.provider == key_r.provider);
    fin      = busy && (hit || ((idx == count) && !rd_valid));
    issue    = busy && !fin && (idx < count);
  end

  // Write pairs into the table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_pair;
    end
  end

  // Read one entry per cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[idx[IdxW-1:0]];
    end
  end

  // Search control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      idx      <= '0;
      seen     <= 1'b0;
      res      <= '0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rd_valid <= 1'b0;
        idx      <= '0;
        seen     <= 1'b0;
        key_r    <= key;
      end else if (busy) begin
        rd_valid <= issue;
        seen     <= seen | cust_hit;
        if (issue) begin
          idx <= idx + CntW'(1);
        end
        if (fin) begin
          busy      <= 1'b0;
          res.done  <= 1'b1;
          res.found <= hit;
          res.seen  <= seen | cust_hit;
        end
      end
    end
  end

endmodule

>>> sv/as_path_relation_validator_top.sv
// AS path relation validator: keeps a table of up to TABLE_ENTRIES customer-provider
// AS pairs and checks route AS paths against it, one segment request at a time. An
// add request is written straight into the table from the idle state. A segment that
// needs a pair lookup searches the table one entry per cycle through the single read
// port of the pair memory, and stops early when the exact pair is found; a segment
// that needs no lookup skips the search, and the last segment of a path also loads
// the verdict register. The next request is accepted while a verdict waits.
// Uses aspv_pkg, the three channel interfaces and aspv_pair_scan.
module as_path_relation_validator_top #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst,
  aspv_req_if.sink   request,
  aspv_rsp_if.source result,
  aspv_cfg_if.sink   cfg
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]  state;
  logic [31:0] local_as;
  logic [1:0]  session_rel;
  logic [CntW-1:0] pair_count;
  logic        path_open;
  logic        decided;
  logic [1:0]  held;
  logic [1:0]  phase;
  logic [31:0] prev_hop;
  logic [31:0] seg_hop;
  logic        seg_last;
  logic        need_lookup;
  logic        need_unknown;
  logic [1:0]  pend_verdict;
  logic        out_valid;
  logic [1:0]  out_verdict;

  logic        accept;
  logic        add_req;
  logic        seg_req;
  logic        table_full;
  logic        seq_type;
  logic        checked;
  logic        reverse;
  logic [31:0] prev_use;
  aspv_pkg::pair_t     scan_key;
  aspv_pkg::pair_t     add_pair;
  aspv_pkg::scan_res_t scan_res;
  logic        out_load;

  logic [1:0]  look;
  logic [1:0]  phase_next;
  logic        decided_next;
  logic [1:0]  held_next;
  logic [1:0]  verdict_next;

  assign request.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign result.valid   = out_valid;
  assign result.verdict = out_verdict;

  // Decode the incoming request
  always_comb begin
    accept     = request.valid && request.ready;
    add_req    = accept && (request.operation == aspv_pkg::OP_ADD_PAIR);
    seg_req    = accept && (request.operation == aspv_pkg::OP_SEGMENT);
    table_full = (pair_count == CntW'(TABLE_ENTRIES));
    seq_type   = (request.segment_type == aspv_pkg::SEG_SEQUENCE) ||
                 (request.segment_type == aspv_pkg::SEG_CONFED_SEQ);
    checked    = (request.segment_length != 8'd0) && !decided && !session_rel[1];
    prev_use   = path_open ? prev_hop : local_as;
    reverse    = (session_rel != aspv_pkg::SESS_CUSTOMER) &&
                 ((phase == aspv_pkg::PH_VALID2) || (phase == aspv_pkg::PH_UNK2));
    scan_key.customer = reverse ? request.segment_last_as : prev_use;
    scan_key.provider = reverse ? prev_use : request.segment_last_as;
    add_pair.customer = request.customer_as;
    add_pair.provider = request.upstream_as;
  end

  aspv_pair_scan #(
    .Entries (TABLE_ENTRIES)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (add_req && !table_full),
    .wr_addr (pair_count[IdxW-1:0]),
    .wr_pair (add_pair),
    .start   (seg_req && checked && seq_type),
    .key     (scan_key),
    .count   (pair_count),
    .res     (scan_res)
  );

  // Apply the hop outcome and form the verdict
  always_comb begin
    if (scan_res.found) begin
      look = aspv_pkg::LOOK_VALID;
    end else if (scan_res.seen) begin
      look = aspv_pkg::LOOK_INVALID;
    end else begin
      look = aspv_pkg::LOOK_UNKNOWN;
    end
    phase_next   = phase;
    decided_next = decided;
    held_next    = held;
    if (need_lookup) begin
      if (session_rel == aspv_pkg::SESS_CUSTOMER) begin
        if (look == aspv_pkg::LOOK_UNKNOWN) begin
          phase_next = aspv_pkg::PH_UNK1;
        end else if (look == aspv_pkg::LOOK_INVALID) begin
          decided_next = 1'b1;
          held_next    = aspv_pkg::V_INVALID;
        end
      end else begin
        unique case (phase)
          aspv_pkg::PH_VALID1: begin
            if (look == aspv_pkg::LOOK_UNKNOWN) begin
              phase_next = aspv_pkg::PH_UNK1;
            end else if (look == aspv_pkg::LOOK_INVALID) begin
              phase_next = aspv_pkg::PH_VALID2;
            end
          end
          aspv_pkg::PH_UNK1: begin
            if (look == aspv_pkg::LOOK_INVALID) begin
              phase_next = aspv_pkg::PH_UNK2;
            end
          end
          aspv_pkg::PH_VALID2: begin
            if (look == aspv_pkg::LOOK_INVALID) begin
              decided_next = 1'b1;
              held_next    = aspv_pkg::V_INVALID;
            end else if (look == aspv_pkg::LOOK_UNKNOWN) begin
              phase_next = aspv_pkg::PH_UNK2;
            end
          end
          default: begin
            if (look == aspv_pkg::LOOK_INVALID) begin
              decided_next = 1'b1;
              held_next    = aspv_pkg::V_INVALID;
            end
          end
        endcase
      end
    end
    if (need_unknown) begin
      decided_next = 1'b1;
      held_next    = aspv_pkg::V_UNKNOWN;
    end
    if (session_rel[1]) begin
      verdict_next = aspv_pkg::V_UNKNOWN;
    end else if (decided_next) begin
      verdict_next = held_next;
    end else if (session_rel == aspv_pkg::SESS_CUSTOMER) begin
      verdict_next = (phase_next == aspv_pkg::PH_VALID1) ? aspv_pkg::V_VALID
                                                         : aspv_pkg::V_UNKNOWN;
    end else begin
      verdict_next = ((phase_next == aspv_pkg::PH_VALID1) ||
                      (phase_next == aspv_pkg::PH_VALID2)) ? aspv_pkg::V_VALID
                                                           : aspv_pkg::V_UNKNOWN;
    end
  end

  assign out_load = (state == ST_EMIT) && (!out_valid || result.ready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_as    <= 32'd0;
      session_rel <= aspv_pkg::SESS_OTHER;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        aspv_pkg::CFG_LOCAL_AS:         local_as    <= cfg.data;
        aspv_pkg::CFG_SESSION_RELATION: session_rel <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pair_count <= '0;
      path_open  <= 1'b0;
      decided    <= 1'b0;
      held       <= aspv_pkg::V_VALID;
      phase      <= aspv_pkg::PH_VALID1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (add_req && !table_full) begin
            pair_count <= pair_count + CntW'(1);
          end
          if (seg_req) begin
            path_open    <= 1'b1;
            prev_hop     <= prev_use;
            seg_hop      <= request.segment_last_as;
            seg_last     <= request.last_segment;
            need_lookup  <= checked && seq_type;
            need_unknown <= checked && !seq_type;
            state        <= (checked && seq_type) ? ST_SCAN : ST_APPLY;
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          phase   <= phase_next;
          decided <= decided_next;
          held    <= held_next;
          if (need_lookup) begin
            prev_hop <= seg_hop;
          end
          pend_verdict <= verdict_next;
          state        <= seg_last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          // Close the path once the verdict is in the output register
          if (out_load) begin
            path_open <= 1'b0;
            decided   <= 1'b0;
            held      <= aspv_pkg::V_VALID;
            phase     <= aspv_pkg::PH_VALID1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict <= pend_verdict;
    end
  end

endmodule

>>> sv/aspv_checker.sv
// Port-level checker for the AS path relation validator, bound to the top level.
// Sees the request and result channel ports only; uses aspv_pkg for codes.
module aspv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_verdict
);

  // Hold a stalled verdict
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict))
    else $error("verdict dropped or changed while stalled");

  // Never emit the unused verdict code
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_verdict == aspv_pkg::V_VALID) ||
                  (out_verdict == aspv_pkg::V_INVALID) ||
                  (out_verdict == aspv_pkg::V_UNKNOWN))
    else $error("verdict outside its code set");

  // An accepted segment request closes the input in the following cycle
  a_seg_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_operation == aspv_pkg::OP_SEGMENT) |=> !in_ready)
    else $error("segment request did not stall the input");

  // Leave reset with the input open and no verdict showing
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind as_path_relation_validator_top aspv_checker u_aspv_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (request.valid),
  .in_ready     (request.ready),
  .in_operation (request.operation),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_verdict  (result.verdict)
);

>>> tb/sv/as_path_relation_validator_top_tb.sv
// Self-checking testbench for as_path_relation_validator_top: pair adds and path segments
// are driven through the request channel and every verdict is checked against a local model or a fixed value.
// Depends on aspv_pkg, the three channel interfaces and the validator RTL.
module as_path_relation_validator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAIR_SLOTS   = 64;
  localparam int DRAIN_CYCLES = 2 * PAIR_SLOTS + 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RAND_BLOCKS  = 16;
  localparam int BLOCK_ITEMS  = 106;
  localparam int POOL_SIZE    = 12;
  localparam int POOL_CUST    = 9;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic        op;
    logic [31:0] cust;
    logic [31:0] prov;
    logic [7:0]  stype;
    logic [7:0]  slen;
    logic [31:0] hop;
    logic        last;
  } route_req_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ADD, ROW_SEG} row_kind_t;

  // One directed step: register write, pair add or segment, with an optional fixed verdict
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  stype;
    logic [7:0]  slen;
    logic        last;
    logic        typed;
    logic [1:0]  want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_SEG, 8'd0, 32'd5, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b1, 1'b1, aspv_pkg::V_UNKNOWN},
    '{ROW_CFG, aspv_pkg::CFG_SESSION_RELATION, {30'd0, aspv_pkg::SESS_CUSTOMER}, 32'd0,
      8'd0, 8'd0, 1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_CFG, aspv_pkg::CFG_LOCAL_AS, 32'hFFFFFFFF, 32'd0, 8'd0, 8'd0,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_ADD, 8'd0, 32'hFFFFFFFF, 32'h0, 8'd0, 8'd0, 1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_ADD, 8'd0, 32'h0, 32'hFFFFFFFF, 8'd0, 8'd0, 1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd255,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'hFFFFFFFF, 32'd0, aspv_pkg::SEG_CONFED_SEQ, 8'd1,
      1'b1, 1'b1, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'd7, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b1, 1'b1, aspv_pkg::V_INVALID},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, 8'd99, 8'd0, 1'b1, 1'b1, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, aspv_pkg::SEG_SET, 8'd3,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b1, 1'b1, aspv_pkg::V_UNKNOWN},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, aspv_pkg::SEG_CONFED_SET, 8'd1,
      1'b1, 1'b1, aspv_pkg::V_UNKNOWN},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, 8'hFF, 8'd1, 1'b1, 1'b1, aspv_pkg::V_UNKNOWN},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, 8'h00, 8'd1, 1'b1, 1'b1, aspv_pkg::V_UNKNOWN},
    '{ROW_CFG, aspv_pkg::CFG_LOCAL_AS, 32'h0000ABCD, 32'd0, 8'd0, 8'd0,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b1, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'hFFFFFFFF, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_CFG, aspv_pkg::CFG_SESSION_RELATION, {30'd0, aspv_pkg::SESS_PROVIDER}, 32'd0,
      8'd0, 8'd0, 1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_CFG, aspv_pkg::CFG_LOCAL_AS, 32'h0, 32'd0, 8'd0, 8'd0,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'd5, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b1, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'hFFFFFFFF, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'd9, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b0, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'h0, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b1, 1'b0, aspv_pkg::V_VALID},
    '{ROW_SEG, 8'd0, 32'd3, 32'd0, aspv_pkg::SEG_SEQUENCE, 8'd1,
      1'b0, 1'b0, aspv_pkg::V_VALID}
  };

  logic clk;
  logic rst;

  aspv_req_if req_ch ();
  aspv_rsp_if rsp_ch ();
  aspv_cfg_if cfg_ch ();

  as_path_relation_validator_top #(
    .TABLE_ENTRIES(PAIR_SLOTS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .request(req_ch),
    .result (rsp_ch),
    .cfg    (cfg_ch)
  );

  // Model state: relation table, walk progress and register copies
  logic [31:0] rel_cust [PAIR_SLOTS];
  logic [31:0] rel_prov [PAIR_SLOTS];
  int          rel_count;
  logic [1:0]  walk_phase;
  logic [31:0] prior_hop;
  bit          path_active;
  bit          path_decided;
  logic [1:0]  held_verdict;
  logic [31:0] cfg_local_as;
  logic [1:0]  cfg_session;

  logic [1:0]  pending_verdicts [$];
  logic [31:0] as_pool [POOL_SIZE];

  int idle_pct;
  int stall_pct;
  int error_count;
  int cycle_count;
  int n_requests;
  int n_verdicts;
  int n_writes;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
               pending_verdicts.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Scan the table the way the block does: exact pair, customer only, or nothing
  function automatic logic [1:0] pair_lookup(input logic [31:0] c, input logic [31:0] p);
    bit seen;
    seen = 1'b0;
    for (int i = 0; i < rel_count; i++) begin
      if (rel_cust[i] == c) begin
        seen = 1'b1;
        if (rel_prov[i] == p) return aspv_pkg::LOOK_VALID;
      end
    end
    return seen ? aspv_pkg::LOOK_INVALID : aspv_pkg::LOOK_UNKNOWN;
  endfunction

  // Advance the customer check or the provider valley check by one hop
  task automatic advance_hop(input logic [31:0] prev, input logic [31:0] curr);
    logic [1:0] look;
    if (cfg_session == aspv_pkg::SESS_CUSTOMER) begin
      look = pair_lookup(prev, curr);
      if (look == aspv_pkg::LOOK_UNKNOWN) walk_phase = aspv_pkg::PH_UNK1;
      else if (look == aspv_pkg::LOOK_INVALID) begin
        path_decided = 1'b1;
        held_verdict = aspv_pkg::V_INVALID;
      end
      return;
    end
    case (walk_phase)
      aspv_pkg::PH_VALID1: begin
        look = pair_lookup(prev, curr);
        if (look == aspv_pkg::LOOK_UNKNOWN) walk_phase = aspv_pkg::PH_UNK1;
        else if (look == aspv_pkg::LOOK_INVALID) walk_phase = aspv_pkg::PH_VALID2;
      end
      aspv_pkg::PH_UNK1: begin
        if (pair_lookup(prev, curr) == aspv_pkg::LOOK_INVALID)
          walk_phase = aspv_pkg::PH_UNK2;
      end
      aspv_pkg::PH_VALID2: begin
        look = pair_lookup(curr, prev);
        if (look == aspv_pkg::LOOK_INVALID) begin
          path_decided = 1'b1;
          held_verdict = aspv_pkg::V_INVALID;
        end else if (look == aspv_pkg::LOOK_UNKNOWN) walk_phase = aspv_pkg::PH_UNK2;
      end
      default: begin
        if (pair_lookup(curr, prev) == aspv_pkg::LOOK_INVALID) begin
          path_decided = 1'b1;
          held_verdict = aspv_pkg::V_INVALID;
        end
      end
    endcase
  endtask

  // Apply one accepted request to the model; report the verdict it causes, if any
  task automatic predict_request(input route_req_t r, output bit has_v, output logic [1:0] v);
    has_v = 1'b0;
    v = aspv_pkg::V_VALID;
    if (r.op == aspv_pkg::OP_ADD_PAIR) begin
      // drop adds once the table is full
      if (rel_count < PAIR_SLOTS) begin
        rel_cust[rel_count] = r.cust;
        rel_prov[rel_count] = r.prov;
        rel_count++;
      end
      return;
    end
    if (!path_active) begin
      path_active = 1'b1;
      prior_hop = cfg_local_as;
    end
    if (r.slen != 8'd0 && !path_decided && cfg_session <= aspv_pkg::SESS_PROVIDER) begin
      if (r.stype == aspv_pkg::SEG_SEQUENCE || r.stype == aspv_pkg::SEG_CONFED_SEQ) begin
        advance_hop(prior_hop, r.hop);
        prior_hop = r.hop;
      end else begin
        path_decided = 1'b1;
        held_verdict = aspv_pkg::V_UNKNOWN;
      end
    end
    if (!r.last) return;
    if (cfg_session > aspv_pkg::SESS_PROVIDER) v = aspv_pkg::V_UNKNOWN;
    else if (path_decided) v = held_verdict;
    else if (cfg_session == aspv_pkg::SESS_CUSTOMER)
      v = (walk_phase == aspv_pkg::PH_VALID1) ? aspv_pkg::V_VALID : aspv_pkg::V_UNKNOWN;
    else
      v = (walk_phase == aspv_pkg::PH_VALID1 || walk_phase == aspv_pkg::PH_VALID2) ?
          aspv_pkg::V_VALID : aspv_pkg::V_UNKNOWN;
    has_v = 1'b1;
    // close the path
    path_active = 1'b0;
    path_decided = 1'b0;
    held_verdict = aspv_pkg::V_VALID;
    walk_phase = aspv_pkg::PH_VALID1;
    prior_hop = cfg_local_as;
  endtask

  // Drive one request at the falling edge, hold it until accepted, then predict
  task automatic send_request(input route_req_t r, input bit typed, input logic [1:0] typed_v);
    bit         has_v;
    logic [1:0] v;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.operation       = r.op;
    req_ch.customer_as     = r.cust;
    req_ch.upstream_as     = r.prov;
    req_ch.segment_type    = r.stype;
    req_ch.segment_length  = r.slen;
    req_ch.segment_last_as = r.hop;
    req_ch.last_segment    = r.last;
    req_ch.valid           = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(r, has_v, v);
    if (has_v) pending_verdicts.push_back(typed ? typed_v : v);
    n_requests++;
  endtask

  // Drop valid and wait for all verdicts; optionally let the last lookup finish
  task automatic wait_block_idle(input bit settle);
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    if (settle) repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [7:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == aspv_pkg::CFG_LOCAL_AS) cfg_local_as = data;
    else if (idx == aspv_pkg::CFG_SESSION_RELATION) cfg_session = data[1:0];
    n_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Pick a hop that chains onto the current one through the table, else from the pool
  function automatic logic [31:0] pick_hop();
    logic [31:0] prev;
    int          cand [$];
    int          roll;
    prev = path_active ? prior_hop : cfg_local_as;
    roll = $urandom_range(99);
    if (roll < 40) begin
      for (int i = 0; i < rel_count; i++) if (rel_cust[i] == prev) cand.push_back(i);
      if (cand.size() != 0) return rel_prov[cand[$urandom_range(cand.size() - 1)]];
    end else if (roll < 60) begin
      for (int i = 0; i < rel_count; i++) if (rel_prov[i] == prev) cand.push_back(i);
      if (cand.size() != 0) return rel_cust[cand[$urandom_range(cand.size() - 1)]];
    end
    return as_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // Result side: random back-pressure, changed at the falling edge
  initial begin : result_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each verdict with the oldest prediction
  always @(posedge clk) begin : check_verdicts
    logic [1:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("verdict %0d with no path pending", rsp_ch.verdict));
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_ch.verdict !== want)
          flag_mismatch($sformatf("verdict %0d, expected %0d", rsp_ch.verdict, want));
        n_verdicts++;
      end
    end
  end

  initial begin : stimulus
    route_req_t  r;
    dir_row_t    row;
    int          sent;
    int          nseg;
    int          roll;
    logic [31:0] la;
    logic [1:0]  sess;

    // Known values on every input from time zero
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = aspv_pkg::OP_ADD_PAIR;
    req_ch.customer_as = '0;
    req_ch.upstream_as = '0;
    req_ch.segment_type = '0;
    req_ch.segment_length = '0;
    req_ch.segment_last_as = '0;
    req_ch.last_segment = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    cycle_count = 0;
    n_requests = 0;
    n_verdicts = 0;
    n_writes = 0;

    // Model reset state
    rel_count = 0;
    cfg_local_as = 32'd0;
    cfg_session = aspv_pkg::SESS_OTHER;
    walk_phase = aspv_pkg::PH_VALID1;
    prior_hop = 32'd0;
    path_active = 1'b0;
    path_decided = 1'b0;
    held_verdict = aspv_pkg::V_VALID;

    as_pool[0] = 32'h0;
    as_pool[1] = 32'hFFFFFFFF;
    for (int i = 2; i < POOL_SIZE; i++) as_pool[i] = $urandom;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      case (row.kind)
        ROW_CFG: begin
          wait_block_idle(1'b1);
          write_register(row.idx, row.a);
        end
        ROW_ADD: begin
          r = '{aspv_pkg::OP_ADD_PAIR, row.a, row.b, 8'd0, 8'd0, 32'd0, 1'b0};
          send_request(r, 1'b0, aspv_pkg::V_VALID);
        end
        default: begin
          r = '{aspv_pkg::OP_SEGMENT, 32'd0, 32'd0, row.stype, row.slen, row.a, row.last};
          send_request(r, row.typed, row.want);
        end
      endcase
    end

    // Random blocks, each with its own register setting and idle mix
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      if (blk == 0) la = 32'h0;
      else if (blk == 1) la = 32'hFFFFFFFF;
      else if ($urandom_range(99) < 70) la = as_pool[$urandom_range(POOL_SIZE - 1)];
      else la = $urandom;
      roll = $urandom_range(99);
      if (blk < 3) sess = blk[1:0];
      else sess = (roll < 45) ? aspv_pkg::SESS_CUSTOMER :
                  (roll < 90) ? aspv_pkg::SESS_PROVIDER : aspv_pkg::SESS_OTHER;
      wait_block_idle(1'b1);
      write_register(aspv_pkg::CFG_LOCAL_AS, la);
      write_register(aspv_pkg::CFG_SESSION_RELATION, {30'd0, sess});

      sent = 0;
      while (sent < BLOCK_ITEMS) begin
        if ($urandom_range(99) < ((rel_count < PAIR_SLOTS) ? 30 : 4)) begin
          // pair add, mostly from the pool; segment fields carry noise
          r.op = aspv_pkg::OP_ADD_PAIR;
          if ($urandom_range(99) < 80) begin
            r.cust = as_pool[$urandom_range(POOL_CUST - 1)];
            r.prov = as_pool[$urandom_range(POOL_SIZE - 1)];
          end else begin
            r.cust = $urandom;
            r.prov = $urandom;
          end
          r.stype = 8'($urandom_range(255));
          r.slen = 8'($urandom_range(255));
          r.hop = $urandom;
          r.last = 1'($urandom_range(1));
          send_request(r, 1'b0, aspv_pkg::V_VALID);
          sent++;
        end else begin
          // hold off now and then until every verdict is back
          if ($urandom_range(29) == 0) wait_block_idle(1'b0);
          nseg = $urandom_range(1, 5);
          for (int s = 0; s < nseg; s++) begin
            r.op = aspv_pkg::OP_SEGMENT;
            r.cust = $urandom;
            r.prov = $urandom;
            r.last = (s == nseg - 1);
            roll = $urandom_range(99);
            if (roll < 85) begin
              r.stype = $urandom_range(1) ? aspv_pkg::SEG_SEQUENCE : aspv_pkg::SEG_CONFED_SEQ;
              r.slen = (roll < 5) ? 8'd0 : 8'($urandom_range(1, 255));
              r.hop = pick_hop();
            end else begin
              if (roll < 92)
                r.stype = $urandom_range(1) ? aspv_pkg::SEG_SET : aspv_pkg::SEG_CONFED_SET;
              else r.stype = 8'($urandom_range(255));
              r.slen = 8'($urandom_range(255));
              r.hop = $urandom;
            end
            send_request(r, 1'b0, aspv_pkg::V_VALID);
            sent++;
            // change the session mid-path once in a while
            if (!r.last && $urandom_range(59) == 0) begin
              wait_block_idle(1'b1);
              write_register(aspv_pkg::CFG_SESSION_RELATION,
                             {30'd0, 2'($urandom_range(2))});
            end
          end
        end
      end
    end

    // Drain
    wait_block_idle(1'b1);
    if (pending_verdicts.size() != 0)
      flag_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

    $display("run covered %0d requests and %0d register writes; %0d verdicts compared",
             n_requests, n_writes, n_verdicts);
    $display("relation table held %0d of %0d entries; %0d mismatches",
             rel_count, PAIR_SLOTS, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> as_path_relation_validator_top.f
sv/aspv_pkg.sv
sv/aspv_req_if.sv
sv/aspv_rsp_if.sv
sv/aspv_cfg_if.sv
sv/aspv_pair_scan.sv
sv/as_path_relation_validator_top.sv
sv/aspv_checker.sv
tb/sv/as_path_relation_validator_top_tb.sv
